// ===== src/bfdh_pkg.sv =====
// Package for the double-hashing Bloom filter unit: field widths, register
// indexes, sequencer states and the control structs shared by the modules.
// No dependencies.
package bfdh_pkg;

  // Field and register widths
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int BYTE_W     = 8;
  localparam int H1_W       = 32;
  localparam int H2_W       = 64;
  localparam int BITCNT_W   = 6;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 8'd1;

  // Register reset values
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd65536;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd4;

  // Item operations
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED_STRIDE,
    ST_SAVE_STRIDE,
    ST_RED_START,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_FINISH
  } state_e;

  // Operations of the shared remainder unit
  typedef enum logic [1:0] {
    MOD_HOLD,
    MOD_CLEAR,
    MOD_SHIFT,
    MOD_ADD
  } mod_op_e;

  typedef struct packed {
    mod_op_e op;
    logic    bit_in;
  } mod_ctrl_t;

  typedef struct packed {
    logic valid;
    logic present;
  } result_t;

  typedef struct packed {
    logic idle;
    logic probing;
  } status_t;

endpackage

// ===== src/bfdh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/bfdh_mod_unit.sv =====
// Shared remainder unit: bit-serial reduction of a dividend modulo the filter
// size, and modular stepping by the stride. Depends on bfdh_pkg.
module bfdh_mod_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bfdh_pkg::mod_ctrl_t         ctrl_i,
  input  logic [bfdh_pkg::SIZE_W-1:0] size_i,
  input  logic [bfdh_pkg::SIZE_W-1:0] addend_i,
  output logic [bfdh_pkg::SIZE_W-1:0] rem_o
);
  import bfdh_pkg::*;

  logic [SIZE_W:0]   sum;
  logic [SIZE_W:0]   diff;
  logic [SIZE_W-1:0] rem_q, rem_d;

  // One compare-subtract on either a shifted-in bit or a stride add;
  // the operand is always below twice the size
  always_comb begin
    case (ctrl_i.op)
      MOD_SHIFT: sum = {rem_q, ctrl_i.bit_in};
      MOD_ADD:   sum = {1'b0, rem_q} + {1'b0, addend_i};
      default:   sum = {1'b0, rem_q};
    endcase
    diff = sum - {1'b0, size_i};
    case (ctrl_i.op)
      MOD_CLEAR:         rem_d = '0;
      MOD_SHIFT, MOD_ADD: begin
        rem_d = (sum >= {1'b0, size_i}) ? diff[SIZE_W-1:0] : sum[SIZE_W-1:0];
      end
      default:           rem_d = rem_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

// ===== src/bfdh_ctrl.sv =====
// Sequencer of the Bloom filter unit: clearing pass, the two reductions,
// probe reads and read-modify-writes of the bit store. Depends on bfdh_pkg.
module bfdh_ctrl #(
  parameter int DEPTH = 8192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input transaction
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [bfdh_pkg::H1_W-1:0]        hash_primary_i,
  input  logic [bfdh_pkg::H2_W-1:0]        hash_secondary_raw_i,
  // active configuration
  input  logic [bfdh_pkg::SIZE_W-1:0]      size_i,
  input  logic [bfdh_pkg::COUNT_W-1:0]     count_i,
  // shared remainder unit
  output bfdh_pkg::mod_ctrl_t              mod_ctrl_o,
  output logic [bfdh_pkg::SIZE_W-1:0]      stride_o,
  input  logic [bfdh_pkg::SIZE_W-1:0]      rem_i,
  // bit store
  output logic                             ram_we_o,
  output logic [AW-1:0]                    ram_waddr_o,
  output logic [bfdh_pkg::BYTE_W-1:0]      ram_wdata_o,
  output logic [AW-1:0]                    ram_raddr_o,
  input  logic [bfdh_pkg::BYTE_W-1:0]      ram_rdata_i,
  // result
  output bfdh_pkg::result_t                result_o,
  input  logic                             out_full_i,
  output bfdh_pkg::status_t                status_o
);
  import bfdh_pkg::*;

  state_e              state_q, state_d;
  logic                op_q, op_d;
  logic [H1_W-1:0]     h1_q, h1_d;
  logic [H2_W-1:0]     sh_q, sh_d;
  logic [SIZE_W-1:0]   stride_q, stride_d;
  logic [BITCNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]  pcnt_q, pcnt_d;
  logic                present_q, present_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [BYTE_W-1:0]   mask;
  logic                hit;
  logic                in_fire;

  // Probed bit within the byte read back
  assign mask    = BYTE_W'(1) << rem_i[2:0];
  assign hit     = |(ram_rdata_i & mask);
  assign in_fire = in_valid_i && !in_stall_o;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign stride_o     = stride_q;
  assign ram_raddr_o  = AW'(rem_i >> 3);
  assign status_o     = '{idle: (state_q == ST_IDLE), probing: (state_q == ST_PROBE_RD) ||
                          (state_q == ST_PROBE_CHK)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      cnt_q     <= '0;
      pcnt_q    <= '0;
      present_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      cnt_q     <= cnt_d;
      pcnt_q    <= pcnt_d;
      present_q <= present_d;
    end
  end

  // Item payload and stride
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    h1_q     <= h1_d;
    sh_q     <= sh_d;
    stride_q <= stride_d;
  end

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    h1_d        = h1_q;
    sh_d        = sh_q;
    stride_d    = stride_q;
    cnt_d       = cnt_q;
    pcnt_d      = pcnt_q;
    present_d   = present_q;
    clr_d       = clr_q;
    mod_ctrl_o  = '{op: MOD_HOLD, bit_in: 1'b0};
    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(rem_i >> 3);
    ram_wdata_o = ram_rdata_i | mask;
    result_o    = '{valid: 1'b0, present: present_q};

    case (state_q)
      // Zero the store one byte per cycle after reset
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = '0;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          op_d       = op_i;
          h1_d       = hash_primary_i;
          sh_d       = hash_secondary_raw_i;
          cnt_d      = '0;
          mod_ctrl_o = '{op: MOD_CLEAR, bit_in: 1'b0};
          if (size_i == '0) begin
            present_d = 1'b0;
            state_d   = ST_FINISH;
          end else begin
            state_d = ST_RED_STRIDE;
          end
        end
      end

      // Secondary hash mod size, MSB first
      ST_RED_STRIDE: begin
        mod_ctrl_o = '{op: MOD_SHIFT, bit_in: sh_q[H2_W-1]};
        sh_d       = sh_q << 1;
        cnt_d      = cnt_q + BITCNT_W'(1);
        if (cnt_q == BITCNT_W'(H2_W - 1)) begin
          state_d = ST_SAVE_STRIDE;
        end
      end

      // Zero stride becomes one; then reduce the primary hash, or finish when the hash count is zero
      ST_SAVE_STRIDE: begin
        stride_d   = (rem_i == '0) ? SIZE_W'(1) : rem_i;
        sh_d       = {h1_q, {(H2_W - H1_W){1'b0}}};
        cnt_d      = '0;
        pcnt_d     = '0;
        present_d  = 1'b1;
        mod_ctrl_o = '{op: MOD_CLEAR, bit_in: 1'b0};
        state_d    = (count_i == '0) ? ST_FINISH : ST_RED_START;
      end

      ST_RED_START: begin
        mod_ctrl_o = '{op: MOD_SHIFT, bit_in: sh_q[H2_W-1]};
        sh_d       = sh_q << 1;
        cnt_d      = cnt_q + BITCNT_W'(1);
        if (cnt_q == BITCNT_W'(H1_W - 1)) begin
          state_d = ST_PROBE_RD;
        end
      end

      // Read address is driven from the current index
      ST_PROBE_RD: begin
        state_d = ST_PROBE_CHK;
      end

      // Set or test the bit, then step the index by the stride while probes remain
      ST_PROBE_CHK: begin
        if (op_q == OP_ADD) begin
          ram_we_o = 1'b1;
        end
        if ((op_q == OP_QUERY) && !hit) begin
          present_d = 1'b0;
          state_d   = ST_FINISH;
        end else if (pcnt_q == (count_i - COUNT_W'(1))) begin
          state_d = ST_FINISH;
        end else begin
          pcnt_d     = pcnt_q + COUNT_W'(1);
          mod_ctrl_o = '{op: MOD_ADD, bit_in: 1'b0};
          state_d    = ST_PROBE_RD;
        end
      end

      // Hand the result over once the output register is free
      ST_FINISH: begin
        result_o = '{valid: 1'b1, present: (op_q == OP_QUERY) && present_q};
        if (!out_full_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/bloom_filter_double_hash_unit.sv =====
// Top level of the double-hashing Bloom filter unit: configuration registers,
// output register, and the sequencer, remainder unit and bit store.
// Depends on bfdh_pkg, bfdh_ram, bfdh_mod_unit and bfdh_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries op_i, hash_primary_i and
//   hash_secondary_raw_i. An add sets k bits of the store, a query reports
//   possibly_present_o = 1 when all k probed bits are set (stops early at the
//   first clear bit). Every transaction yields one result on the output
//   channel (out_valid_o / out_stall_i); adds report 0.
//   Configuration writes (cfg_valid_i / cfg_ready_o) go to filter size
//   (index 0) and hash count (index 1) and are taken only while idle.
// Sequence:
//   One item at a time. The secondary hash is reduced bit-serially through
//   the shared remainder unit, then the primary hash, then each probe reads
//   the store's single read port and then sets or tests the probed bit. A new
//   item is taken only once the result is handed to the output register.
// Reset:
//   Registers return to size 65536 and k = 4. The store is cleared by a pass
//   over its (MAX_FILTER_BITS+7)/8 bytes (8192 by default); in_stall_o is high meanwhile.
//   While the receiver stalls, the result is held and no new item is taken.
module bloom_filter_double_hash_unit #(
  parameter int MAX_FILTER_BITS = 65536,
  parameter int MAX_HASHES      = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [bfdh_pkg::H1_W-1:0]       hash_primary_i,
  input  logic [bfdh_pkg::H2_W-1:0]       hash_secondary_raw_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            possibly_present_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfdh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfdh_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfdh_pkg::*;

  localparam int STORE_BYTES = (MAX_FILTER_BITS + 7) / 8;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;
  logic [SIZE_W-1:0]  size_act;
  logic [COUNT_W-1:0] count_act;
  logic               out_valid_q;
  logic               out_present_q;
  logic               out_full;
  mod_ctrl_t          mod_ctrl;
  logic [SIZE_W-1:0]  stride;
  logic [SIZE_W-1:0]  rem;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [BYTE_W-1:0]  ram_rdata;
  result_t            result;
  status_t            status;

  // Registers change only between items
  assign cfg_ready_o = status.idle;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FILTER_SIZE: size_q  <= cfg_data_i[SIZE_W-1:0];
        REG_HASH_COUNT:  count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the store size and the probe limit
  assign size_act  = (32'(size_q) > 32'(MAX_FILTER_BITS)) ? SIZE_W'(MAX_FILTER_BITS) : size_q;
  assign count_act = (32'(count_q) > 32'(MAX_HASHES)) ? COUNT_W'(MAX_HASHES) : count_q;

  // Output register
  assign out_full = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (result.valid && !out_full) || out_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid && !out_full) begin
      out_present_q <= result.present;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign possibly_present_o = out_present_q;

  bfdh_ctrl #(
    .DEPTH (STORE_BYTES)
  ) u_ctrl (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .op_i                 (op_i),
    .hash_primary_i       (hash_primary_i),
    .hash_secondary_raw_i (hash_secondary_raw_i),
    .size_i               (size_act),
    .count_i              (count_act),
    .mod_ctrl_o           (mod_ctrl),
    .stride_o             (stride),
    .rem_i                (rem),
    .ram_we_o             (ram_we),
    .ram_waddr_o          (ram_waddr),
    .ram_wdata_o          (ram_wdata),
    .ram_raddr_o          (ram_raddr),
    .ram_rdata_i          (ram_rdata),
    .result_o             (result),
    .out_full_i           (out_full),
    .status_o             (status)
  );

  bfdh_mod_unit u_mod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mod_ctrl),
    .size_i   (size_act),
    .addend_i (stride),
    .rem_o    (rem)
  );

  bfdh_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An accepted transaction makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted transaction did not leave idle");

  // A finished result waits while the output register is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid && out_full |=> result.valid)
    else $error("result dropped while output was full");

  // A handed-over result shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result.valid && !out_full |=> out_valid_o)
    else $error("result not registered");

  // Probe index stays inside the active filter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.probing |-> rem < size_act)
    else $error("probe index out of range");

endmodule
